>>> rtl/slfr_pkg.sv
package slfr_pkg;

  localparam int unsigned PosW      = 25;
  localparam int unsigned LenW      = 32;
  localparam int unsigned MaxPayW   = 24;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 24;

  localparam int unsigned SyncLen    = 6;
  localparam int unsigned PosType    = 6;
  localparam int unsigned PosLenLast = 10;
  localparam int unsigned HeaderLen  = 11;
  localparam int unsigned TrailerLen = 4;

  // byte roles
  localparam logic [2:0] RoleDrop    = 3'd0;
  localparam logic [2:0] RoleSync    = 3'd1;
  localparam logic [2:0] RoleType    = 3'd2;
  localparam logic [2:0] RoleLen     = 3'd3;
  localparam logic [2:0] RolePayload = 3'd4;
  localparam logic [2:0] RoleTrailer = 3'd5;

  // input actions
  localparam logic ActReceive = 1'b0;
  localparam logic ActResync  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLenBigEndian = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload   = 2'd1;

  localparam logic [MaxPayW-1:0] MaxPayloadReset = 24'd65535;

  typedef struct packed {
    logic               len_big_endian;
    logic [MaxPayW-1:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      byte_out;
    logic [2:0]      byte_role;
    logic            header_seen;
    logic            frame_done;
    logic [7:0]      frame_type;
    logic [LenW-1:0] payload_length;
    logic            length_error;
  } res_t;

  // expected sync byte at a hunting position
  function automatic logic [7:0] sync_byte(input logic [2:0] pos);
    logic [7:0] b;
    unique case (pos)
      3'd0:    b = 8'h4e;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h49;
      3'd3:    b = 8'h4f;
      3'd4:    b = 8'h30;
      3'd5:    b = 8'h31;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/slfr_if.sv
interface slfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, action, rx_byte, input ready);
  modport sink   (input valid, action, rx_byte, output ready);
endinterface

interface slfr_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    byte_out;
  logic [2:0]                    byte_role;
  logic                          header_seen;
  logic                          frame_done;
  logic [7:0]                    frame_type;
  logic [slfr_pkg::LenW-1:0]     payload_length;
  logic                          length_error;

  modport source (output valid, byte_out, byte_role, header_seen, frame_done, frame_type,
                  payload_length, length_error, input ready);
  modport sink   (input valid, byte_out, byte_role, header_seen, frame_done, frame_type,
                  payload_length, length_error, output ready);
endinterface

interface slfr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [slfr_pkg::CfgIdxW-1:0]     index;
  logic [slfr_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/slfr_core.sv
module slfr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                action_i,
  input  logic [7:0]          rx_byte_i,
  input  slfr_pkg::cfg_t      cfg_i,
  output slfr_pkg::res_t      res_o
);

  logic [slfr_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                type_q, type_d;
  logic [slfr_pkg::LenW-1:0] len_q, len_d;

  logic [slfr_pkg::PosW-1:0] payload_end;
  logic [slfr_pkg::PosW-1:0] last_pos;
  logic [slfr_pkg::LenW-1:0] len_shift;

  // length is bounded by max_payload once past the header
  assign payload_end = slfr_pkg::PosW'(slfr_pkg::HeaderLen)
                     + {1'b0, len_q[slfr_pkg::MaxPayW-1:0]};
  assign last_pos    = payload_end + slfr_pkg::PosW'(slfr_pkg::TrailerLen - 1);
  assign len_shift   = cfg_i.len_big_endian ? {len_q[slfr_pkg::LenW-9:0], rx_byte_i}
                                            : {rx_byte_i, len_q[slfr_pkg::LenW-1:8]};

  always_comb begin
    pos_d = pos_q;
    type_d = type_q;
    len_d = len_q;
    res_o.byte_out = rx_byte_i;
    res_o.byte_role = slfr_pkg::RoleDrop;
    res_o.header_seen = 1'b0;
    res_o.frame_done = 1'b0;
    res_o.length_error = 1'b0;
    if (action_i == slfr_pkg::ActResync) begin
      pos_d = '0;
      res_o.byte_out = '0;
    end else if (pos_q < slfr_pkg::PosW'(slfr_pkg::SyncLen)) begin
      if (rx_byte_i == slfr_pkg::sync_byte(pos_q[2:0])) begin
        res_o.byte_role = slfr_pkg::RoleSync;
        res_o.header_seen = (pos_q == slfr_pkg::PosW'(slfr_pkg::SyncLen - 1));
        pos_d = pos_q + 1'b1;
      end else begin
        pos_d = '0;
      end
    end else if (pos_q == slfr_pkg::PosW'(slfr_pkg::PosType)) begin
      res_o.byte_role = slfr_pkg::RoleType;
      type_d = rx_byte_i;
      pos_d = pos_q + 1'b1;
    end else if (pos_q <= slfr_pkg::PosW'(slfr_pkg::PosLenLast)) begin
      res_o.byte_role = slfr_pkg::RoleLen;
      len_d = len_shift;
      if (pos_q == slfr_pkg::PosW'(slfr_pkg::PosLenLast) &&
          len_shift > {8'd0, cfg_i.max_payload}) begin
        res_o.length_error = 1'b1;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end else if (pos_q < payload_end) begin
      res_o.byte_role = slfr_pkg::RolePayload;
      pos_d = pos_q + 1'b1;
    end else begin
      res_o.byte_role = slfr_pkg::RoleTrailer;
      if (pos_q >= last_pos) begin
        res_o.frame_done = 1'b1;
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
    res_o.frame_type = type_d;
    res_o.payload_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      type_q <= '0;
      len_q <= '0;
    end else if (adv_i) begin
      pos_q <= pos_d;
      type_q <= type_d;
      len_q <= len_d;
    end
  end

endmodule

>>> rtl/sync_length_frame_receiver.sv
// Byte-stream frame receiver. Hunts for the sync word 4e 41 49 4f 30 31, then takes a type
// byte, a four-byte payload length (byte order set by len_big_endian), the payload and a
// four-byte trailer; every byte comes back as one result item tagged with its role. A byte
// that breaks the sync is dropped and not retried as a new start. A length above max_payload
// flags length_error and returns to hunting; an item with action set restarts hunting. One
// item per cycle sustained while results are taken; an item is held in an input register,
// processed by the frame tracker in one pass and lands in the result register, from which
// its result is presented. The result register decouples the sides: one more item is taken
// while a result waits, then the input stalls until the result is taken. Configuration writes
// are always ready and take effect next cycle.
module sync_length_frame_receiver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slfr_in_if.sink               in_i,
  slfr_out_if.source            out_o,
  slfr_cfg_if.sink              cfg_i
);

  // configuration registers
  slfr_pkg::cfg_t cfg_q;

  // input register
  logic       in_vld_q;
  logic       in_action_q;
  logic [7:0] in_byte_q;

  // result register
  logic           out_vld_q;
  slfr_pkg::res_t out_res_q;
  slfr_pkg::res_t step_res;

  logic adv;
  logic in_acc;

  // move the held item into the result slot when that slot is free or draining
  assign adv      = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;
  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.len_big_endian <= 1'b0;
      cfg_q.max_payload <= slfr_pkg::MaxPayloadReset;
    end else if (cfg_i.valid) begin
      // writes beyond the register list fall through
      if (cfg_i.index == slfr_pkg::CfgLenBigEndian) begin
        cfg_q.len_big_endian <= cfg_i.data[0];
      end else if (cfg_i.index == slfr_pkg::CfgMaxPayload) begin
        cfg_q.max_payload <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload of the input register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_action_q <= in_i.action;
      in_byte_q <= in_i.rx_byte;
    end
  end

  // frame tracking state and per-byte decode
  slfr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .action_i  (in_action_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg_q),
    .res_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= step_res;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.byte_out       = out_res_q.byte_out;
  assign out_o.byte_role      = out_res_q.byte_role;
  assign out_o.header_seen    = out_res_q.header_seen;
  assign out_o.frame_done     = out_res_q.frame_done;
  assign out_o.frame_type     = out_res_q.frame_type;
  assign out_o.payload_length = out_res_q.payload_length;
  assign out_o.length_error   = out_res_q.length_error;

  // header completion only ever comes on a sync byte
  a_hdr_on_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.header_seen |-> out_res_q.byte_role == slfr_pkg::RoleSync)
    else $error("header_seen on a non-sync byte");

  // length error only on a length byte
  a_err_on_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_res_q.length_error |-> out_res_q.byte_role == slfr_pkg::RoleLen)
    else $error("length_error on a non-length byte");

  // a held item that cannot move blocks new input
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv |-> !in_i.ready)
    else $error("input taken while the input register is stuck");

  // an advanced item always shows as a result
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item lost");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 120;
  localparam int unsigned MaxPrinted  = 40;
  // indexes past the two registers, written to check that they are ignored
  localparam logic [slfr_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [slfr_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;
  // the six bytes that open every frame
  localparam logic [7:0] SyncWord [slfr_pkg::SyncLen] =
    '{8'h4e, 8'h41, 8'h49, 8'h4f, 8'h30, 8'h31};

  // frame tracker model: follows every accepted item and holds the results it implies
  class frame_tracker_model;
    logic [slfr_pkg::PosW-1:0]    pos;
    logic [7:0]                   type_q;
    logic [slfr_pkg::LenW-1:0]    len_q;
    logic                         big_endian;
    logic [slfr_pkg::MaxPayW-1:0] max_len;
    slfr_pkg::res_t               pending_results[$];
    int                           errors;
    int                           n_checked;

    function new();
      pos        = '0;
      type_q     = '0;
      len_q      = '0;
      big_endian = 1'b0;
      max_len    = slfr_pkg::MaxPayloadReset;
      errors     = 0;
      n_checked  = 0;
    endfunction

    function void set_reg(logic [slfr_pkg::CfgIdxW-1:0] idx,
                          logic [slfr_pkg::CfgDataW-1:0] data);
      case (idx)
        slfr_pkg::CfgLenBigEndian: big_endian = data[0];
        slfr_pkg::CfgMaxPayload:   max_len = data[slfr_pkg::MaxPayW-1:0];
        default: ;
      endcase
    endfunction

    // work out the result of one accepted item
    function void take_item(logic act, logic [7:0] b);
      slfr_pkg::res_t r;
      logic [32:0]    payload_end;
      r = '0;
      r.byte_out  = b;
      r.byte_role = slfr_pkg::RoleDrop;
      if (act == slfr_pkg::ActResync) begin
        pos = '0;
        r.byte_out = '0;
      end else if (pos < slfr_pkg::SyncLen) begin
        // a mismatching byte is dropped and not tried again as a first sync byte
        if (b == SyncWord[pos[2:0]]) begin
          r.byte_role   = slfr_pkg::RoleSync;
          r.header_seen = (pos == slfr_pkg::SyncLen - 1);
          pos++;
        end else begin
          pos = '0;
        end
      end else if (pos == slfr_pkg::PosType) begin
        r.byte_role = slfr_pkg::RoleType;
        type_q = b;
        pos++;
      end else if (pos <= slfr_pkg::PosLenLast) begin
        r.byte_role = slfr_pkg::RoleLen;
        len_q = big_endian ? {len_q[23:0], b} : {b, len_q[31:8]};
        if (pos == slfr_pkg::PosLenLast && len_q > max_len) begin
          r.length_error = 1'b1;
          pos = '0;
        end else begin
          pos++;
        end
      end else begin
        payload_end = 33'(slfr_pkg::HeaderLen) + len_q;
        if (pos < payload_end) begin
          r.byte_role = slfr_pkg::RolePayload;
          pos++;
        end else begin
          r.byte_role = slfr_pkg::RoleTrailer;
          if (pos >= payload_end + slfr_pkg::TrailerLen - 1) begin
            r.frame_done = 1'b1;
            pos = '0;
          end else begin
            pos++;
          end
        end
      end
      r.frame_type     = type_q;
      r.payload_length = len_q;
      pending_results = {pending_results, r};
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (errors < MaxPrinted)
        $display("mismatch at result %0d: %s got %h expected %h", n_checked, what, got, want);
      errors++;
    endtask

    task cmp_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
    endtask

    task check_result(slfr_pkg::res_t got);
      slfr_pkg::res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, byte_out", 32'(got.byte_out), '0);
      end else begin
        want = pending_results.pop_front();
        cmp_field("byte_out", 32'(got.byte_out), 32'(want.byte_out));
        cmp_field("byte_role", 32'(got.byte_role), 32'(want.byte_role));
        cmp_field("header_seen", 32'(got.header_seen), 32'(want.header_seen));
        cmp_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        cmp_field("frame_type", 32'(got.frame_type), 32'(want.frame_type));
        cmp_field("payload_length", got.payload_length, want.payload_length);
        cmp_field("length_error", 32'(got.length_error), 32'(want.length_error));
      end
      n_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  slfr_in_if  in_if();
  slfr_out_if out_if();
  slfr_cfg_if cfg_if();

  sync_length_frame_receiver dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  frame_tracker_model chk = new();

  bit          idle_on;      // random idling on both sides
  int unsigned rx_hold;      // cycles the receiver still holds off
  int unsigned items_sent;
  int unsigned cycle_count;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // everything is sampled at the rising edge, before the block updates
  always @(posedge clk) begin : monitor
    slfr_pkg::res_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) chk.set_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) chk.take_item(in_if.action, in_if.rx_byte);
      if (out_if.valid && out_if.ready) begin
        got.byte_out       = out_if.byte_out;
        got.byte_role      = out_if.byte_role;
        got.header_seen    = out_if.header_seen;
        got.frame_done     = out_if.frame_done;
        got.frame_type     = out_if.frame_type;
        got.payload_length = out_if.payload_length;
        got.length_error   = out_if.length_error;
        chk.check_result(got);
      end
    end
  end

  // result side: random stalls, or a long hold-off counted down here
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else begin
        out_if.ready = !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one item, with random gaps ahead of it; called and returns just after a falling edge
  task automatic send_item(input logic act, input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 31) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid   = 1'b1;
    in_if.action  = act;
    in_if.rx_byte = b;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic drain();
    in_if.valid = 1'b0;
    while (chk.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [slfr_pkg::CfgIdxW-1:0] idx,
                           input logic [slfr_pkg::CfgDataW-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // length register write with random junk above the used bit
  task automatic set_byte_order(input logic big);
    logic [slfr_pkg::CfgDataW-1:0] data;
    data = slfr_pkg::CfgDataW'($urandom);
    data[0] = big;
    cfg_write(slfr_pkg::CfgLenBigEndian, data);
  endtask

  // sync word, type, length in the current byte order, then payload and trailer
  // unless the length is over the limit; cut < 0 sends the whole frame
  task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len, input int cut);
    logic [7:0] frame_bytes[$];
    int         n;
    foreach (SyncWord[i]) frame_bytes = {frame_bytes, SyncWord[i]};
    frame_bytes = {frame_bytes, ftype};
    for (int i = 0; i < 4; i++)
      frame_bytes = {frame_bytes, (chk.big_endian ? len[8*(3-i) +: 8] : len[8*i +: 8])};
    if (len <= chk.max_len)
      repeat (len + slfr_pkg::TrailerLen) frame_bytes = {frame_bytes, 8'($urandom)};
    n = (cut < 0 || cut > frame_bytes.size()) ? frame_bytes.size() : cut;
    for (int i = 0; i < n; i++) send_item(slfr_pkg::ActReceive, frame_bytes[i]);
  endtask

  // one random step: mostly whole frames, the rest cut frames, broken sync,
  // lone resyncs and noise
  task automatic random_step();
    int unsigned r;
    int unsigned k;
    int unsigned lim;
    logic [7:0]  b;
    logic [31:0] len;
    r = $urandom_range(99);
    if (r < 70) begin
      if ($urandom_range(99) < 8) begin
        // length over the limit
        len = $urandom;
        if (len <= chk.max_len) len = chk.max_len + 1 + len[7:0];
        if ($urandom_range(9) == 0) len = '1;
      end else begin
        lim = ($urandom_range(19) == 0) ? 200 : 12;
        if (lim > chk.max_len) lim = chk.max_len;
        len = $urandom_range(lim, 0);
      end
      if (r < 60) begin
        send_frame(8'($urandom), len, -1);
      end else begin
        send_frame(8'($urandom), len, $urandom_range(14, 1));
        send_item(slfr_pkg::ActResync, 8'($urandom));
      end
    end else if (r < 80) begin
      // partial sync word, then a wrong byte
      k = $urandom_range(slfr_pkg::SyncLen - 1, 0);
      for (int i = 0; i < k; i++) send_item(slfr_pkg::ActReceive, SyncWord[i]);
      do b = 8'($urandom); while (b == SyncWord[k]);
      send_item(slfr_pkg::ActReceive, b);
    end else if (r < 88) begin
      send_item(slfr_pkg::ActResync, 8'($urandom));
    end else begin
      repeat ($urandom_range(4, 1)) send_item(slfr_pkg::ActReceive, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    in_if.valid   = 1'b0;
    in_if.action  = slfr_pkg::ActReceive;
    in_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = slfr_pkg::CfgLenBigEndian;
    cfg_if.data   = '0;
    idle_on       = 1'b1;
    rx_hold       = 0;
    items_sent    = 0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part, registers at reset values
    // sync broken on its third byte: the wrong 4e is dropped, not taken as a new start
    send_item(slfr_pkg::ActReceive, 8'h4e);
    send_item(slfr_pkg::ActReceive, 8'h41);
    send_item(slfr_pkg::ActReceive, 8'h4e);
    send_item(slfr_pkg::ActReceive, 8'h41);
    // shortest frame: zero length, all-ones type
    send_frame(8'hff, 32'h0, -1);
    // resync in the middle of the sync word
    send_frame(8'h00, 32'h0, 3);
    send_item(slfr_pkg::ActResync, 8'hff);
    // all-ones length is over the limit and returns to hunting
    send_frame(8'h00, 32'hffff_ffff, -1);
    // byte order switched between length bytes
    send_frame(8'h5a, 32'h0000_0102, 9);
    drain();
    set_byte_order(1'b1);
    send_item(slfr_pkg::ActReceive, 8'h00);
    send_item(slfr_pkg::ActReceive, 8'h01);
    send_item(slfr_pkg::ActResync, 8'h00);

    // random phases, each with its own register setting
    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: begin
          set_byte_order(1'b0);
          cfg_write(slfr_pkg::CfgMaxPayload, slfr_pkg::MaxPayloadReset);
        end
        1: begin
          // zero limit, no idling at all on either side
          set_byte_order(1'b1);
          cfg_write(slfr_pkg::CfgMaxPayload, '0);
          idle_on = 1'b0;
        end
        2: begin
          set_byte_order(1'b0);
          cfg_write(slfr_pkg::CfgMaxPayload, '1);
          idle_on = 1'b1;
          // long receiver hold-off while items keep coming, so the block backs up
          rx_hold = 300;
        end
        3: begin
          set_byte_order(1'b1);
          cfg_write(slfr_pkg::CfgMaxPayload, slfr_pkg::CfgDataW'($urandom_range(40, 1)));
          cfg_write(CfgSpareA, slfr_pkg::CfgDataW'($urandom));
          cfg_write(CfgSpareB, slfr_pkg::CfgDataW'($urandom));
        end
        default: begin
          set_byte_order(1'($urandom));
          cfg_write(slfr_pkg::CfgMaxPayload, slfr_pkg::CfgDataW'($urandom));
        end
      endcase
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) random_step();
    end

    drain();
    repeat (10) @(negedge clk);
    if (chk.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sync_length_frame_receiver.f
rtl/slfr_pkg.sv
rtl/slfr_if.sv
rtl/slfr_core.sv
rtl/sync_length_frame_receiver.sv
tb/tb.sv
